[src/psc_pkg.sv]
// ----------------------------------------------------------------------------
// PNG chunk span scanner package
// Shared types and constants: scan phases, status codes, signature bytes and
// the beats passed between the input stage, the scan core and the result stage.
// ----------------------------------------------------------------------------
package psc_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADSIG = 2'd1;
  localparam logic [1:0] ST_TRUNC  = 2'd2;
  localparam logic [1:0] ST_BADLEN = 2'd3;

  // Chunk type IEND with its first byte in the low bits.
  localparam logic [31:0] IEND_CODE = 32'h444E_4549;
  // Every chunk ends with a 4-byte CRC.
  localparam logic [31:0] CRC_BYTES = 32'd4;
  // Largest byte count; the counter saturates here.
  localparam logic [31:0] SIZE_MAX  = 32'hFFFF_FFFF;
  // Smallest complete image: signature plus one empty chunk.
  localparam logic [31:0] MIN_IMAGE = 32'd20;

  // Scan phases, one-hot.
  typedef enum logic [4:0] {
    PH_SIG   = 5'b00001,
    PH_LEN   = 5'b00010,
    PH_TYPE  = 5'b00100,
    PH_SKIP  = 5'b01000,
    PH_DRAIN = 5'b10000
  } psc_phase_t;

  // One input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } psc_item_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] image_size;
  } psc_result_t;

  // Expected byte of the 8-byte PNG signature at a given position.
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0: val = 8'd137;
      3'd1: val = 8'd80;
      3'd2: val = 8'd78;
      3'd3: val = 8'd71;
      3'd4: val = 8'd13;
      3'd5: val = 8'd10;
      3'd6: val = 8'd26;
      3'd7: val = 8'd10;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

endpackage

[src/png_chunk_span_scanner_unit.sv]
// ----------------------------------------------------------------------------
// PNG chunk span scanner
// Walks a byte stream and reports the byte span of one embedded PNG image.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (valid, ready, data_byte, stream_end) carries one byte
//   per beat; stream_end marks the last byte of a stream. The result channel
//   (result_valid, result_ready, status, image_size) carries at most one beat
//   per input beat: ok with the image size, bad signature, truncated stream
//   or bad chunk length. After a result, bytes are dropped up to the stream
//   end, and the next byte starts a new scan.
//   A beat accepted into the input register is stepped through the scan core
//   once the result register has room and, if it makes a result, is loaded
//   into the result register. The block takes one byte every cycle as long
//   as the result register is empty or being drained; the single step of the
//   scan core between the input and result registers sets that rate.
//   When the receiver stalls with a result held, the scan core stops and the
//   input register holds its byte, so ready falls.
//   Reset clears the scan state and empties both registers.
// ----------------------------------------------------------------------------
module png_chunk_span_scanner_unit
  import psc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [7:0]  data_byte,
  input  logic        stream_end,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  status,
  output logic [31:0] image_size
);

  psc_item_t   item_in;
  psc_item_t   item;
  psc_result_t res;
  logic        item_valid;
  logic        take;
  logic        res_hit;
  logic        out_free;

  assign item_in.data_byte  = data_byte;
  assign item_in.stream_end = stream_end;

  // A registered byte is stepped when the result register has room.
  assign take = item_valid && out_free;

  psc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .valid      (valid),
    .ready      (ready),
    .item_in    (item_in),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  psc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (item),
    .res_hit (res_hit),
    .res     (res)
  );

  psc_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (take && res_hit),
    .res          (res),
    .free         (out_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .image_size   (image_size)
  );

  // A successful scan spans at least the signature and one empty chunk.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_OK) |-> (image_size >= MIN_IMAGE))
    else $error("ok result with an image size below the minimum");

  // Failure results carry no size.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_OK) |-> (image_size == 32'd0))
    else $error("failure result with a nonzero image size");

  // A held byte blocked by a full result register must back-pressure the input.
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !out_free) |-> !ready)
    else $error("input accepted while a stalled byte is held");

endmodule

[src/psc_in_stage.sv]
// ----------------------------------------------------------------------------
// PNG chunk span scanner input stage
// Registers one input beat and offers it to the scan core.
// ----------------------------------------------------------------------------
module psc_in_stage
  import psc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      valid,
  output logic      ready,
  input  psc_item_t item_in,
  input  logic      take,
  output logic      item_valid,
  output psc_item_t item
);

  // The register can load when it is empty or its beat leaves this cycle.
  assign ready = !item_valid || take;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (ready) begin
      item_valid <= valid;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (valid && ready) begin
      item <= item_in;
    end
  end

endmodule

[src/psc_core.sv]
// ----------------------------------------------------------------------------
// PNG chunk span scanner core
// Holds the scan state and advances it by one byte for each beat taken,
// producing at most one result beat.
// ----------------------------------------------------------------------------
module psc_core
  import psc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  psc_item_t   item,
  output logic        res_hit,
  output psc_result_t res
);

  psc_phase_t  phase, phase_next;
  logic [2:0]  field_index, field_index_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] chunk_type, chunk_type_next;
  logic [31:0] skip_remaining, skip_remaining_next;
  logic [31:0] bytes_seen, bytes_seen_next;
  logic        final_chunk, final_chunk_next;

  logic [31:0] bytes_inc;
  logic [31:0] len_shift;
  logic [31:0] type_or;
  logic [2:0]  fi_inc;
  logic [31:0] skip_dec;
  logic        restart;

  // Per-byte arithmetic shared by the phases.
  always_comb begin
    bytes_inc = (bytes_seen == SIZE_MAX) ? bytes_seen : bytes_seen + 32'd1;
    len_shift = {chunk_length[23:0], item.data_byte};
    type_or   = chunk_type | ({24'd0, item.data_byte} << {field_index[1:0], 3'b000});
    fi_inc    = field_index + 3'd1;
    skip_dec  = (skip_remaining == 32'd0) ? skip_remaining : skip_remaining - 32'd1;
  end

  // Next scan state and result.
  always_comb begin
    phase_next          = phase;
    field_index_next    = field_index;
    chunk_length_next   = chunk_length;
    chunk_type_next     = chunk_type;
    skip_remaining_next = skip_remaining;
    bytes_seen_next     = bytes_seen;
    final_chunk_next    = final_chunk;
    res_hit             = 1'b0;
    res.status          = ST_OK;
    res.image_size      = 32'd0;
    restart             = 1'b0;

    if (take) begin
      if (phase == PH_DRAIN) begin
        // Bytes after a result are dropped until the stream ends.
        restart = item.stream_end;
      end else begin
        bytes_seen_next = bytes_inc;
        unique case (phase)
          PH_SIG: begin
            if (item.data_byte != sig_byte(field_index)) begin
              res_hit    = 1'b1;
              res.status = ST_BADSIG;
            end else begin
              field_index_next = fi_inc;
              if (fi_inc == 3'd0) begin
                phase_next = PH_LEN;
              end
            end
          end
          PH_LEN: begin
            chunk_length_next = len_shift;
            field_index_next  = fi_inc;
            if (fi_inc == 3'd4) begin
              field_index_next = 3'd0;
              if (len_shift[31]) begin
                res_hit    = 1'b1;
                res.status = ST_BADLEN;
              end else begin
                chunk_type_next = 32'd0;
                phase_next      = PH_TYPE;
              end
            end
          end
          PH_TYPE: begin
            chunk_type_next  = type_or;
            field_index_next = fi_inc;
            if (fi_inc == 3'd4) begin
              field_index_next    = 3'd0;
              final_chunk_next    = (type_or == IEND_CODE);
              skip_remaining_next = chunk_length + CRC_BYTES;
              phase_next          = PH_SKIP;
            end
          end
          PH_SKIP: begin
            skip_remaining_next = skip_dec;
            if (skip_dec == 32'd0) begin
              if (final_chunk) begin
                res_hit        = 1'b1;
                res.status     = ST_OK;
                res.image_size = bytes_inc;
              end else begin
                chunk_length_next = 32'd0;
                field_index_next  = 3'd0;
                phase_next        = PH_LEN;
              end
            end
          end
          PH_DRAIN: begin
            phase_next = PH_DRAIN;
          end
          default: begin
            phase_next = PH_SIG;
          end
        endcase

        // A result either restarts the scan or waits for the stream end;
        // an end with no result of its own means the stream was cut short.
        if (res_hit) begin
          if (item.stream_end) begin
            restart = 1'b1;
          end else begin
            phase_next = PH_DRAIN;
          end
        end else if (item.stream_end) begin
          res_hit    = 1'b1;
          res.status = ST_TRUNC;
          restart    = 1'b1;
        end
      end
    end

    if (restart) begin
      phase_next          = PH_SIG;
      field_index_next    = 3'd0;
      chunk_length_next   = 32'd0;
      chunk_type_next     = 32'd0;
      skip_remaining_next = 32'd0;
      bytes_seen_next     = 32'd0;
      final_chunk_next    = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SIG;
      field_index    <= 3'd0;
      chunk_length   <= 32'd0;
      chunk_type     <= 32'd0;
      skip_remaining <= 32'd0;
      bytes_seen     <= 32'd0;
      final_chunk    <= 1'b0;
    end else begin
      phase          <= phase_next;
      field_index    <= field_index_next;
      chunk_length   <= chunk_length_next;
      chunk_type     <= chunk_type_next;
      skip_remaining <= skip_remaining_next;
      bytes_seen     <= bytes_seen_next;
      final_chunk    <= final_chunk_next;
    end
  end

endmodule

[src/psc_out_stage.sv]
// ----------------------------------------------------------------------------
// PNG chunk span scanner result stage
// Result register that holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module psc_out_stage
  import psc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  psc_result_t res,
  output logic        free,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  status,
  output logic [31:0] image_size
);

  // The slot is free when empty or when its beat is taken this cycle.
  assign free = !result_valid || result_ready;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      status     <= res.status;
      image_size <= res.image_size;
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG chunk span scanner testbench
// Drives byte streams into the scanner: well-formed images with random chunk
// content, plus truncated streams, corrupted signatures, oversized lengths and
// noise. A scoreboard tracks the scan state for every accepted byte, queues
// the expected status and image size, and compares each result beat in order.
// Both channels idle and stall at random, and the receiver holds off long
// enough at times to back the scanner up into its input.
// ----------------------------------------------------------------------------
module tb;
  import psc_pkg::*;

  localparam int          RX_HOLD_CYCLES = 500;
  localparam int          ITEM_TARGET    = 1400;
  localparam int          RESULT_TARGET  = 48;
  localparam logic [31:0] LEN_LIMIT      = 32'h7FFF_FFFF;
  localparam logic [7:0]  PNG_MAGIC [8]  = '{8'd137, 8'd80, 8'd78, 8'd71,
                                            8'd13, 8'd10, 8'd26, 8'd10};

  logic        clk;
  logic        rst;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        stream_end;
  logic        result_valid;
  logic        result_ready;
  logic [1:0]  status;
  logic [31:0] image_size;

  // Shared between the sender and the receiver.
  bit quiet = 1'b0;
  bit rx_hold_req = 1'b0;

  // Bytes of the stream being built, sent front to back.
  logic [7:0] stream_q[$];

  // Tracks the scan for every accepted byte and holds the expected results.
  class span_scoreboard;
    psc_phase_t  phase;
    logic [2:0]  field_idx;
    logic [31:0] len_acc;
    logic [31:0] type_acc;
    logic [32:0] skip_left;
    logic [31:0] byte_count;
    bit          is_iend;
    psc_result_t span_q[$];
    int          fails;
    int          scanned_items;
    int          results_due;

    function new();
      fails = 0;
      scanned_items = 0;
      results_due = 0;
      restart();
    endfunction

    function void restart();
      phase      = PH_SIG;
      field_idx  = '0;
      len_acc    = '0;
      type_acc   = '0;
      skip_left  = '0;
      byte_count = '0;
      is_iend    = 1'b0;
    endfunction

    // Queue one result and either restart or drain to the stream end.
    function void finish_scan(logic [1:0] st, logic [31:0] size, logic last);
      psc_result_t r;
      r.status     = st;
      r.image_size = (st == ST_OK) ? size : 32'd0;
      span_q.push_back(r);
      results_due++;
      if (last) restart();
      else phase = PH_DRAIN;
    endfunction

    function void note_input(logic [7:0] b, logic last);
      if (phase == PH_DRAIN) begin
        if (last) restart();
        return;
      end
      scanned_items++;
      if (byte_count != SIZE_MAX) byte_count++;

      case (phase)
        PH_SIG: begin
          if (b != PNG_MAGIC[field_idx]) begin
            finish_scan(ST_BADSIG, 32'd0, last);
            return;
          end
          field_idx++;
          if (field_idx == 3'd0) phase = PH_LEN;
        end
        PH_LEN: begin
          len_acc = {len_acc[23:0], b};
          field_idx++;
          if (field_idx == 3'd4) begin
            field_idx = '0;
            if (len_acc > LEN_LIMIT) begin
              finish_scan(ST_BADLEN, 32'd0, last);
              return;
            end
            type_acc = '0;
            phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_acc = type_acc | ({24'd0, b} << (8 * field_idx[1:0]));
          field_idx++;
          if (field_idx == 3'd4) begin
            field_idx = '0;
            is_iend   = (type_acc == IEND_CODE);
            skip_left = {1'b0, len_acc} + {1'b0, CRC_BYTES};
            phase     = PH_SKIP;
          end
        end
        default: begin
          if (skip_left != '0) skip_left--;
          if (skip_left == '0) begin
            if (is_iend) begin
              finish_scan(ST_OK, byte_count, last);
              return;
            end
            len_acc   = '0;
            field_idx = '0;
            phase     = PH_LEN;
          end
        end
      endcase

      // A stream end on a byte with no result of its own is a truncation.
      if (last) finish_scan(ST_TRUNC, 32'd0, 1'b1);
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] size);
      psc_result_t want;
      if (span_q.size() == 0) begin
        $error("unexpected result beat: status %0d, image_size %0d", st, size);
        fails++;
        return;
      end
      want = span_q.pop_front();
      if (st !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, st);
        fails++;
      end
      if (size !== want.image_size) begin
        $error("image_size mismatch: expected %0d, actual %0d", want.image_size, size);
        fails++;
      end
    endfunction

    function int pending();
      return span_q.size();
    endfunction
  endclass

  span_scoreboard sb = new();

  png_chunk_span_scanner_unit uut (
    .clk          (clk),
    .rst          (rst),
    .valid        (valid),
    .ready        (ready),
    .data_byte    (data_byte),
    .stream_end   (stream_end),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .image_size   (image_size)
  );

  // Clock, 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_len();
    if ($urandom_range(0, 9) != 0) return $urandom_range(0, 24);
    return $urandom_range(25, 200);
  endfunction

  // Random chunk type; a quarter of them differ from IEND in a single bit.
  function automatic logic [31:0] pick_type();
    if ($urandom_range(0, 3) == 0) return IEND_CODE ^ (32'd1 << $urandom_range(0, 31));
    return $urandom();
  endfunction

  function automatic void put_random(int n);
    for (int i = 0; i < n; i++) stream_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_word_be(logic [31:0] w);
    stream_q.push_back(w[31:24]);
    stream_q.push_back(w[23:16]);
    stream_q.push_back(w[15:8]);
    stream_q.push_back(w[7:0]);
  endfunction

  function automatic void put_signature();
    for (int i = 0; i < 8; i++) stream_q.push_back(PNG_MAGIC[i]);
  endfunction

  // Length, type (first byte in the low bits), data and CRC of one chunk.
  function automatic void put_chunk(logic [31:0] len, logic [31:0] kind);
    put_word_be(len);
    stream_q.push_back(kind[7:0]);
    stream_q.push_back(kind[15:8]);
    stream_q.push_back(kind[23:16]);
    stream_q.push_back(kind[31:24]);
    put_random(int'(len) + 4);
  endfunction

  function automatic void put_chunks(int n);
    for (int i = 0; i < n; i++) put_chunk(pick_len(), pick_type());
  endfunction

  function automatic void cut_stream();
    int keep;
    keep = $urandom_range(1, stream_q.size() - 1);
    while (stream_q.size() > keep) void'(stream_q.pop_back());
  endfunction

  // Offer one beat; valid stays high with the same payload until accepted.
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    valid      <= 1'b1;
    data_byte  <= b;
    stream_end <= last;
    @(posedge clk);
    while (!ready) @(posedge clk);
    sb.note_input(b, last);
  endtask

  // Send the built stream with the end mark on its last byte.
  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++)
      send_byte(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic wait_drained();
    valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: check accepted beats and stall at random or on request.
  initial begin
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) sb.check_result(status, image_size);
      if (rx_hold_req) begin
        hold_left = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // Run limit.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int n;
    int kind;
    int pos;
    int idle;
    rst        = 1'b1;
    valid      = 1'b0;
    data_byte  = 8'd0;
    stream_end = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Smallest image, ending on its completing byte.
    put_signature();
    put_chunk(32'd0, IEND_CODE);
    send_stream();
    // Image with a 13-byte chunk of random type, then bytes to drain.
    put_signature();
    put_chunk(32'd13, pick_type());
    put_chunk(32'd0, IEND_CODE);
    put_random(2);
    send_stream();
    // Stream ends inside the signature.
    stream_q.push_back(PNG_MAGIC[0]);
    send_stream();
    // Signature mismatch on the first byte, which also ends the stream.
    stream_q.push_back(8'h00);
    send_stream();
    // Signature mismatch on the last signature byte, then drain.
    put_signature();
    stream_q[7] = 8'hFF;
    put_random(3);
    send_stream();
    // Length too large, then drain.
    put_signature();
    put_word_be(32'h8000_0000);
    put_random(2);
    send_stream();
    // Length too large on the byte that ends the stream.
    put_signature();
    put_word_be(32'hFFFF_FFFF);
    send_stream();
    // Largest legal length, stream ends inside the data.
    put_signature();
    put_word_be(LEN_LIMIT);
    put_word_be(IEND_CODE);
    put_random(3);
    send_stream();
    // Stream ends right after a chunk other than IEND.
    put_signature();
    put_chunk(32'd5, IEND_CODE ^ 32'h0000_0100);
    send_stream();
    // Stream ends right after the signature.
    put_signature();
    send_stream();
    // IEND missing its last CRC byte.
    put_signature();
    put_chunk(32'd0, IEND_CODE);
    void'(stream_q.pop_back());
    send_stream();
    // IEND carrying data, then drain.
    put_signature();
    put_chunk(32'd6, IEND_CODE);
    put_random(3);
    send_stream();
    // Single all-ones byte.
    stream_q.push_back(8'hFF);
    send_stream();
    wait_drained();

    // Random streams, mostly well-formed images.
    n = 0;
    while ((sb.scanned_items < ITEM_TARGET || sb.results_due < RESULT_TARGET) && n < 4000) begin
      if ($urandom_range(0, 9) == 0) quiet = !quiet;

      // Back the scanner up: the receiver holds off while short streams pile in.
      if (n == 6 || n == 40) begin
        rx_hold_req = 1'b1;
        repeat (12) stream_q.push_back(8'($urandom_range(0, 136)));
        for (int i = 0; i < 12; i++) send_byte(stream_q[i], 1'b1);
        stream_q.delete();
      end

      kind = $urandom_range(0, 99);
      put_signature();
      if (kind < 55) begin
        put_chunks($urandom_range(0, 4));
        put_chunk(($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 0, IEND_CODE);
        put_random($urandom_range(0, 3));
      end else if (kind < 65) begin
        put_chunks($urandom_range(0, 3));
        put_chunk($urandom_range(0, 4), IEND_CODE);
        cut_stream();
      end else if (kind < 73) begin
        put_chunks($urandom_range(1, 3));
      end else if (kind < 81) begin
        pos = $urandom_range(0, 7);
        stream_q[pos] = 8'($urandom_range(0, 255));
        put_random($urandom_range(0, 5));
      end else if (kind < 88) begin
        put_chunks($urandom_range(0, 2));
        put_word_be(32'h8000_0000 | $urandom());
        put_random($urandom_range(0, 3));
      end else if (kind < 95) begin
        stream_q.delete();
        put_random($urandom_range(1, 12));
      end else begin
        put_word_be(($urandom_range(0, 1) != 0) ? LEN_LIMIT : ($urandom() & LEN_LIMIT));
        put_word_be(pick_type());
        put_random($urandom_range(0, 6));
      end
      send_stream();

      if (n % 16 == 15) wait_drained();
      n++;
    end
    valid <= 1'b0;

    // Let the last results come out.
    idle = 0;
    while (sb.pending() != 0 && idle < 100000) begin
      @(posedge clk);
      idle++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) $error("%0d expected results never arrived", sb.pending());
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
